// File: design/ctf_pkg.sv
// ----------------------------------------------------------------------------
// ctf_pkg
// Shared types, constants and CRC helper for the CRC-16 telemetry framer.
// ----------------------------------------------------------------------------
package ctf_pkg;

  localparam int ChanW     = 16;
  localparam int NumChan   = 4;
  localparam int DataW     = ChanW * NumChan;
  localparam int ByteW     = 8;
  localparam int FrameLen  = 10;
  localparam int CrcW      = 16;
  localparam int NumStages = 4;
  localparam int CntW      = $clog2(FrameLen);

  localparam logic [CrcW-1:0] CrcInit = 16'hFFFF;
  localparam logic [CrcW-1:0] CrcPoly = 16'hA001;

  // channel_0 sits in the low bits, so byte 0 of the flat word is ch0 low
  typedef struct packed {
    logic signed [ChanW-1:0] channel_3;
    logic signed [ChanW-1:0] channel_2;
    logic signed [ChanW-1:0] channel_1;
    logic signed [ChanW-1:0] channel_0;
  } ctf_in_t;

  typedef struct packed {
    logic [ByteW-1:0] frame_byte;
    logic             last_byte;
  } ctf_out_t;

  // Reflected CRC-16, one byte, LSB first
  function automatic logic [CrcW-1:0] crc_byte(input logic [CrcW-1:0] crc,
                                               input logic [ByteW-1:0] b);
    logic [CrcW-1:0] c;
    c = crc ^ {{(CrcW-ByteW){1'b0}}, b};
    for (int k = 0; k < ByteW; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// File: design/crc16_telemetry_framer.sv
// ----------------------------------------------------------------------------
// crc16_telemetry_framer
// Frames four 16-bit samples into ten bytes: data LSB first, then CRC-16.
// ----------------------------------------------------------------------------
//   channel | dir | handshake             | payload
//   in      | in  | in_valid / in_stall   | ctf_in_t  (channel_0..channel_3)
//   out     | out | out_valid / out_stall | ctf_out_t (frame_byte, last_byte)
//
// Structure: four CRC stages (two bytes each) then the byte serializer.
// The output sends one byte per cycle while out_stall is low.
// The CRC pipeline holds up to four further items while a frame is sent.
// Reset (rst, synchronous) clears all valid bits and the serializer's busy
// flag and byte counter. out_stall freezes the serializer; the pipeline fills
// behind it, then in_stall rises.
// ----------------------------------------------------------------------------
module crc16_telemetry_framer (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  ctf_pkg::ctf_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output ctf_pkg::ctf_out_t out_data
);
  import ctf_pkg::*;

  // CRC pipeline
  logic [NumStages-1:0] v;
  logic [NumStages-1:0] ld;
  logic [DataW-1:0]     dat [NumStages];
  logic [CrcW-1:0]      crc [NumStages];

  // serializer
  logic                      busy;
  logic [CntW-1:0]           cnt;
  logic [DataW+CrcW-1:0]     sh;
  logic                      last;
  logic                      take;

  assign last = (cnt == CntW'(FrameLen - 1));
  assign take = v[NumStages-1] && (!busy || (!out_stall && last));

  always_comb begin
    ld[NumStages-1] = !v[NumStages-1] || take;
    for (int k = NumStages - 2; k >= 0; k--) begin
      ld[k] = !v[k] || ld[k+1];
    end
  end

  assign in_stall = !ld[0];

  genvar g;
  generate
    for (g = 0; g < NumStages; g++) begin : g_stage
      logic [DataW-1:0] d_in;
      logic [CrcW-1:0]  c_in;
      logic             v_in;
      logic [CrcW-1:0]  c_next;

      if (g == 0) begin : g_first
        assign d_in = in_data;
        assign c_in = CrcInit;
        assign v_in = in_valid;
      end else begin : g_rest
        assign d_in = dat[g-1];
        assign c_in = crc[g-1];
        assign v_in = v[g-1];
      end

      always_comb begin
        c_next = crc_byte(crc_byte(c_in, d_in[2*g*ByteW +: ByteW]),
                          d_in[(2*g+1)*ByteW +: ByteW]);
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          v[g] <= 1'b0;
        end else if (ld[g]) begin
          v[g] <= v_in;
        end
      end

      always_ff @(posedge clk) begin
        if (ld[g] && v_in) begin
          dat[g] <= d_in;
          crc[g] <= c_next;
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (take) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy && !out_stall) begin
      if (last) begin
        busy <= 1'b0;
      end
      cnt <= cnt + CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      sh <= {crc[NumStages-1], dat[NumStages-1]};
    end else if (busy && !out_stall) begin
      sh <= sh >> ByteW;
    end
  end

  assign out_valid           = busy;
  assign out_data.frame_byte = sh[ByteW-1:0];
  assign out_data.last_byte  = last;

`ifndef ASSERT_OFF
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> (cnt <= CntW'(FrameLen - 1)))
    else $error("byte counter past frame end");

  a_busy_fall: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> $past(last && !out_stall))
    else $error("frame ended before last byte was taken");

  a_gap: assert property (@(posedge clk) disable iff (rst)
    (busy && !out_stall && last && !v[NumStages-1]) |=> !out_valid)
    else $error("serializer kept going with no frame ready");

  a_in_enter: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> v[0])
    else $error("accepted item did not enter the pipeline");

  a_refill: assert property (@(posedge clk) disable iff (rst)
    (busy && !out_stall && last && v[NumStages-1]) |=> (out_valid && cnt == '0))
    else $error("queued frame not started after last byte");
`endif

endmodule
